### rtl/mmh3_pkg.sv
// Shared definitions for the MurmurHash3 x64 128-bit hash engine.
// Holds the hash constants, the command record passed from front to back,
// and the state and phase encodings of the mixing sequencer. No dependencies.
package mmh3_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned CountW = 4;
  localparam int unsigned TotalW = 32;
  localparam int unsigned SeedW  = 32;

  // Block round and finalisation constants
  localparam logic [63:0] MulA   = 64'h87c37b91114253d5;
  localparam logic [63:0] MulB   = 64'h4cf5ad432745937f;
  localparam logic [63:0] FmixA  = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FmixB  = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] AddOne = 64'h0000000052dce729;
  localparam logic [63:0] AddTwo = 64'h0000000038495ab5;

  // Command queue geometry
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  // One unit of work for the mixing engine
  typedef struct packed {
    logic              start;  // first command of a key: load the seed
    logic              mix;    // full block round on w1/w2
    logic              lane1;  // h1 ^= lane_one(w1) without a round
    logic              lane2;  // h2 ^= lane_two(w2) without a round
    logic              fin;    // closing command: fold length and finalise
    logic [TotalW-1:0] total;  // key length in bytes, valid with fin
    logic [WordW-1:0]  w1;
    logic [WordW-1:0]  w2;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_POST,
    ST_H1A,
    ST_H1B,
    ST_H2A,
    ST_H2B,
    ST_FIN0,
    ST_FIN1,
    ST_FIN2,
    ST_FIN3,
    ST_FIN4,
    ST_EMIT
  } state_t;

  // Which product is in flight, and so what follows it
  typedef enum logic [2:0] {
    PH_K1A,
    PH_K1B,
    PH_K2A,
    PH_K2B,
    PH_F1A,
    PH_F1B,
    PH_F2A,
    PH_F2B
  } phase_t;

  function automatic logic [63:0] mul_const(input phase_t ph);
    logic [63:0] c;
    unique case (ph)
      PH_K1A: c = MulA;
      PH_K1B: c = MulB;
      PH_K2A: c = MulB;
      PH_K2B: c = MulA;
      PH_F1A: c = FmixA;
      PH_F1B: c = FmixB;
      PH_F2A: c = FmixA;
      PH_F2B: c = FmixB;
      default: c = MulA;
    endcase
    return c;
  endfunction

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned r);
    return (v << r) | (v >> (64 - r));
  endfunction

  function automatic logic [63:0] shr33_xor(input logic [63:0] v);
    return v ^ (v >> 33);
  endfunction

endpackage

### rtl/mmh3_front.sv
// Front end of the hash engine: accepts key words, pairs them into blocks,
// masks the tail and counts the key length, and issues commands.
// Depends on mmh3_pkg.
module mmh3_front import mmh3_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [WordW-1:0]  in_word,
  input  logic [CountW-1:0] in_count,
  input  logic              in_last,
  output logic              push_valid,
  input  logic              push_ready,
  output cmd_t              push_cmd
);

  logic [WordW-1:0]  held_r, held_nxt;
  logic              pending_r, pending_nxt;
  logic              first_r, first_nxt;
  logic [TotalW-1:0] total_r, total_nxt;

  logic              accept;
  logic [CountW-1:0] cnt_sat;
  logic              cnt_full;
  logic              cnt_zero;
  logic [WordW-1:0]  tail_mask;
  logic [WordW-1:0]  masked;
  logic [TotalW-1:0] total_add;
  logic [TotalW-1:0] total_sum;

  // Request is taken whenever the queue has room
  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;

  // Tail classification
  assign cnt_sat   = (in_count > CountW'(8)) ? CountW'(8) : in_count;
  assign cnt_full  = cnt_sat[3];
  assign cnt_zero  = (cnt_sat == '0);
  assign tail_mask = cnt_full ? '1 : ((WordW'(1) << {cnt_sat[2:0], 3'b000}) - WordW'(1));
  assign masked    = in_last ? (in_word & tail_mask) : in_word;
  assign total_add = in_last ? TotalW'(cnt_sat) : TotalW'(8);
  assign total_sum = total_r + total_add;

  // Command build: a block on every second word, one closing command per key
  always_comb begin
    push_valid     = in_valid && (in_last || pending_r);
    push_cmd.start = first_r;
    push_cmd.fin   = in_last;
    push_cmd.total = total_sum;
    push_cmd.mix   = !in_last || (pending_r && cnt_full);
    push_cmd.lane1 = in_last && ((pending_r && !cnt_full) || (!pending_r && !cnt_zero));
    push_cmd.lane2 = in_last && pending_r && !cnt_full && !cnt_zero;
    push_cmd.w1    = pending_r ? held_r : masked;
    push_cmd.w2    = masked;
  end

  // Key bookkeeping
  always_comb begin
    held_nxt    = held_r;
    pending_nxt = pending_r;
    first_nxt   = first_r;
    total_nxt   = total_r;
    if (accept) begin
      if (in_last) begin
        pending_nxt = 1'b0;
        first_nxt   = 1'b1;
        total_nxt   = '0;
      end else begin
        total_nxt = total_sum;
        if (pending_r) begin
          pending_nxt = 1'b0;
          first_nxt   = 1'b0;
        end else begin
          held_nxt    = in_word;
          pending_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      first_r   <= 1'b1;
      total_r   <= '0;
    end else begin
      pending_r <= pending_nxt;
      first_r   <= first_nxt;
      total_r   <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

endmodule

### rtl/mmh3_cmd_fifo.sv
// Two-entry command queue between the front end and the mixing engine.
// Lets either side stall on its own. Depends on mmh3_pkg.
module mmh3_cmd_fifo import mmh3_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_cmd
);

  cmd_t                 slot_r [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QueuePtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QueueCntW-1:0] cnt_r, cnt_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (cnt_r != QueueCntW'(QueueDepth));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointer and fill update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QueueCntW'(do_push) - QueueCntW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### rtl/mmh3_back.sv
// Mixing engine of the hash: block rounds, tail lanes and finalisation on
// one shared 32x32 multiplier, plus the result register. Depends on mmh3_pkg.
module mmh3_back import mmh3_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [SeedW-1:0] seed,
  input  logic             cmd_valid,
  output logic             cmd_pop,
  input  cmd_t             cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WordW-1:0] out_low,
  output logic [WordW-1:0] out_high
);

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [WordW-1:0]  h1_r, h1_nxt;
  logic [WordW-1:0]  h2_r, h2_nxt;
  logic [WordW-1:0]  x_r, x_nxt;
  logic [WordW-1:0]  acc_r, acc_nxt;
  logic [WordW-1:0]  w2_r, w2_nxt;
  logic              mix_r, mix_nxt;
  logic              l2_r, l2_nxt;
  logic              fin_r, fin_nxt;
  logic [TotalW-1:0] total_r, total_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WordW-1:0]  out_low_r, out_low_nxt;
  logic [WordW-1:0]  out_high_r, out_high_nxt;

  logic [63:0] mconst;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  assign out_valid = out_valid_r;
  assign out_low   = out_low_r;
  assign out_high  = out_high_r;

  // Shared multiplier: low x low, then the two cross terms into the top half
  assign mconst = mul_const(phase_r);
  assign mul_a  = (state_r == ST_MUL2) ? x_r[63:32] : x_r[31:0];
  assign mul_b  = (state_r == ST_MUL1) ? mconst[63:32] : mconst[31:0];
  assign prod   = 64'(mul_a) * 64'(mul_b);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    h1_nxt        = h1_r;
    h2_nxt        = h2_r;
    x_nxt         = x_r;
    acc_nxt       = acc_r;
    w2_nxt        = w2_r;
    mix_nxt       = mix_r;
    l2_nxt        = l2_r;
    fin_nxt       = fin_r;
    total_nxt     = total_r;
    out_low_nxt   = out_low_r;
    out_high_nxt  = out_high_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd_pop       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          w2_nxt    = cmd.w2;
          mix_nxt   = cmd.mix;
          l2_nxt    = cmd.mix || cmd.lane2;
          fin_nxt   = cmd.fin;
          total_nxt = cmd.total;
          if (cmd.start) begin
            h1_nxt = WordW'(seed);
            h2_nxt = WordW'(seed);
          end
          if (cmd.mix || cmd.lane1) begin
            x_nxt     = cmd.w1;
            phase_nxt = PH_K1A;
            state_nxt = ST_MUL0;
          end else if (cmd.lane2) begin
            x_nxt     = cmd.w2;
            phase_nxt = PH_K2A;
            state_nxt = ST_MUL0;
          end else if (cmd.fin) begin
            state_nxt = ST_FIN0;
          end
        end
      end
      ST_MUL0: begin
        acc_nxt   = prod;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        acc_nxt[63:32] = acc_r[63:32] + prod[31:0];
        state_nxt      = ST_MUL2;
      end
      ST_MUL2: begin
        acc_nxt[63:32] = acc_r[63:32] + prod[31:0];
        state_nxt      = ST_POST;
      end
      ST_POST: begin
        unique case (phase_r)
          PH_K1A: begin
            x_nxt     = rotl64(acc_r, 31);
            phase_nxt = PH_K1B;
            state_nxt = ST_MUL0;
          end
          PH_K1B: begin
            h1_nxt = h1_r ^ acc_r;
            if (mix_r) begin
              state_nxt = ST_H1A;
            end else if (l2_r) begin
              x_nxt     = w2_r;
              phase_nxt = PH_K2A;
              state_nxt = ST_MUL0;
            end else begin
              state_nxt = fin_r ? ST_FIN0 : ST_IDLE;
            end
          end
          PH_K2A: begin
            x_nxt     = rotl64(acc_r, 33);
            phase_nxt = PH_K2B;
            state_nxt = ST_MUL0;
          end
          PH_K2B: begin
            h2_nxt = h2_r ^ acc_r;
            if (mix_r) begin
              state_nxt = ST_H2A;
            end else begin
              state_nxt = fin_r ? ST_FIN0 : ST_IDLE;
            end
          end
          PH_F1A: begin
            x_nxt     = shr33_xor(acc_r);
            phase_nxt = PH_F1B;
            state_nxt = ST_MUL0;
          end
          PH_F1B: begin
            h1_nxt    = shr33_xor(acc_r);
            x_nxt     = shr33_xor(h2_r);
            phase_nxt = PH_F2A;
            state_nxt = ST_MUL0;
          end
          PH_F2A: begin
            x_nxt     = shr33_xor(acc_r);
            phase_nxt = PH_F2B;
            state_nxt = ST_MUL0;
          end
          PH_F2B: begin
            h2_nxt    = shr33_xor(acc_r);
            state_nxt = ST_FIN3;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      // First half round
      ST_H1A: begin
        h1_nxt    = rotl64(h1_r, 27) + h2_r;
        state_nxt = ST_H1B;
      end
      ST_H1B: begin
        h1_nxt = (h1_r << 2) + h1_r + AddOne;
        if (l2_r) begin
          x_nxt     = w2_r;
          phase_nxt = PH_K2A;
          state_nxt = ST_MUL0;
        end else begin
          state_nxt = fin_r ? ST_FIN0 : ST_IDLE;
        end
      end
      // Second half round
      ST_H2A: begin
        h2_nxt    = rotl64(h2_r, 31) + h1_r;
        state_nxt = ST_H2B;
      end
      ST_H2B: begin
        h2_nxt    = (h2_r << 2) + h2_r + AddTwo;
        state_nxt = fin_r ? ST_FIN0 : ST_IDLE;
      end
      // Length fold and cross adds
      ST_FIN0: begin
        h1_nxt    = h1_r ^ WordW'(total_r);
        h2_nxt    = h2_r ^ WordW'(total_r);
        state_nxt = ST_FIN1;
      end
      ST_FIN1: begin
        h1_nxt    = h1_r + h2_r;
        state_nxt = ST_FIN2;
      end
      ST_FIN2: begin
        h2_nxt    = h2_r + h1_r;
        x_nxt     = shr33_xor(h1_r);
        phase_nxt = PH_F1A;
        state_nxt = ST_MUL0;
      end
      ST_FIN3: begin
        h1_nxt    = h1_r + h2_r;
        state_nxt = ST_FIN4;
      end
      ST_FIN4: begin
        h2_nxt    = h2_r + h1_r;
        state_nxt = ST_EMIT;
      end
      // Hand over to the result register once it is free
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_low_nxt   = h1_r;
          out_high_nxt  = h2_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r    <= phase_nxt;
    h1_r       <= h1_nxt;
    h2_r       <= h2_nxt;
    x_r        <= x_nxt;
    acc_r      <= acc_nxt;
    w2_r       <= w2_nxt;
    mix_r      <= mix_nxt;
    l2_r       <= l2_nxt;
    fin_r      <= fin_nxt;
    total_r    <= total_nxt;
    out_low_r  <= out_low_nxt;
    out_high_r <= out_high_nxt;
  end

  // A product always runs its three partial steps in order
  a_mul_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL0 |=> state_r == ST_MUL1 ##1 state_r == ST_MUL2)
    else $error("multiply sequence broken");

  // Only a closing command reaches the result hand-over
  a_emit_fin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> fin_r)
    else $error("result emitted for a non-closing command");

  // Half rounds run only for full blocks
  a_round_mix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_H1A || state_r == ST_H2A) |-> mix_r)
    else $error("half round without a full block");

endmodule

### rtl/murmur3_128_hash.sv
// The mixing engine takes a new command only once it is back in idle, and its pace
// for blocks and for the closing command is set by the one shared 32x32
// multiplier, which builds each of the 64-bit products from partial products.
// Input words are taken in one cycle each while the two-entry command queue has room.
// Reset: rst_n synchronous, active low; clears the seed to 0 and empties the queue.
module murmur3_128_hash import mmh3_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [71:0]      in_tdata,   // [63:0] data_word, [67:64] byte_count, rest zero
  input  logic             in_tlast,   // last_word
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [127:0]     out_tdata,  // [63:0] hash_low, [127:64] hash_high
  input  logic             cfg_wr_en,
  input  logic [SeedW-1:0] cfg_wr_data // seed_value
);

  logic [SeedW-1:0] seed_r;
  logic             push_valid;
  logic             push_ready;
  cmd_t             push_cmd;
  logic             q_valid;
  logic             q_pop;
  cmd_t             q_cmd;
  logic [WordW-1:0] hash_low;
  logic [WordW-1:0] hash_high;

  // Seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  mmh3_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_word    (in_tdata[63:0]),
    .in_count   (in_tdata[67:64]),
    .in_last    (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  mmh3_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  mmh3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .seed      (seed_r),
    .cmd_valid (q_valid),
    .cmd_pop   (q_pop),
    .cmd       (q_cmd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_low   (hash_low),
    .out_high  (hash_high)
  );

  assign out_tdata = {hash_high, hash_low};

endmodule
